// ----- rtl/core/dbdf_pkg.sv -----
`timescale 1ns / 1ps

package dbdf_pkg;

   localparam int MaxClasses    = 256;
   localparam int ImgMax        = 8192;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CLASS_NUM       = 3'd0,
      CSR_SCORE_THRESHOLD = 3'd1,
      CSR_INVERSE_SCALE   = 3'd2,
      CSR_PAD_LEFT        = 3'd3,
      CSR_PAD_TOP         = 3'd4,
      CSR_IMAGE_WIDTH     = 3'd5,
      CSR_IMAGE_HEIGHT    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [8:0]  class_num;
      logic [15:0] score_threshold;
      logic [23:0] inverse_scale;
      logic [11:0] pad_left;
      logic [11:0] pad_top;
      logic [13:0] image_width;
      logic [13:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic [15:0] candidate_id;
      logic [15:0] class_score;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] box_w_in;
      logic [15:0] box_h_in;
   } req_type;

   typedef struct packed {
      logic [15:0] out_candidate;
      logic [7:0]  out_class;
      logic [15:0] out_score;
      logic [12:0] box_left;
      logic [12:0] box_top;
      logic [13:0] box_width_out;
      logic [13:0] box_height_out;
   } rsp_type;

   // Identity of a kept candidate, carried alongside the box math
   typedef struct packed {
      logic [15:0] candidate_id;
      logic [7:0]  win_class;
      logic [15:0] win_score;
   } meta_type;

   typedef struct packed {
      meta_type    meta;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] box_w;
      logic [15:0] box_h;
   } job_type;

   // Queue handshake between front and back
   typedef struct packed {
      logic    valid;
      job_type job;
   } job_xfer_type;

endpackage

// ----- rtl/core/dbdf_front.sv -----
`timescale 1ns / 1ps

module dbdf_front import dbdf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  cfg_type      cfg,
   input  logic         queue_full,
   output job_xfer_type push
);

   logic [15:0] top_score_ff, top_score_in;
   logic [7:0]  top_class_ff, top_class_in;
   logic        best_valid_ff, best_valid_in;
   logic [7:0]  class_counter_ff, class_counter_in;

   logic        accept;
   logic        last;
   logic        win;
   logic [8:0]  count_eff;
   logic [15:0] upd_score;
   logic [7:0]  upd_class;
   logic        upd_valid;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      if (cfg.class_num == 9'd0) begin
         count_eff = 9'd1;
      end else if (cfg.class_num > 9'(MaxClasses)) begin
         count_eff = 9'(MaxClasses);
      end else begin
         count_eff = cfg.class_num;
      end
   end

   // Strict compare: first maximum wins, zero never wins
   assign win       = req_data.class_score > top_score_ff;
   assign upd_score = win ? req_data.class_score : top_score_ff;
   assign upd_class = win ? class_counter_ff : top_class_ff;
   assign upd_valid = win || best_valid_ff;
   assign last      = ({1'b0, class_counter_ff} + 9'd1) >= count_eff;

   always_comb begin
      top_score_in     = top_score_ff;
      top_class_in     = top_class_ff;
      best_valid_in    = best_valid_ff;
      class_counter_in = class_counter_ff;
      if (accept) begin
         if (last) begin
            top_score_in     = '0;
            top_class_in     = '0;
            best_valid_in    = 1'b0;
            class_counter_in = '0;
         end else begin
            top_score_in     = upd_score;
            top_class_in     = upd_class;
            best_valid_in    = upd_valid;
            class_counter_in = class_counter_ff + 8'd1;
         end
      end
   end

   always_comb begin
      push.valid                  = accept && last && upd_valid &&
                                    (upd_score >= cfg.score_threshold);
      push.job.meta.candidate_id  = req_data.candidate_id;
      push.job.meta.win_class     = upd_class;
      push.job.meta.win_score     = upd_score;
      push.job.center_x           = req_data.center_x;
      push.job.center_y           = req_data.center_y;
      push.job.box_w              = req_data.box_w_in;
      push.job.box_h              = req_data.box_h_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_score_ff     <= '0;
         top_class_ff     <= '0;
         best_valid_ff    <= 1'b0;
         class_counter_ff <= '0;
      end else begin
         top_score_ff     <= top_score_in;
         top_class_ff     <= top_class_in;
         best_valid_ff    <= best_valid_in;
         class_counter_ff <= class_counter_in;
      end
   end

   a_candidate_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (class_counter_ff == 8'd0 && !best_valid_ff &&
                            top_score_ff == 16'd0))
      else $error("argmax state not cleared at end of candidate");

endmodule

// ----- rtl/core/dbdf_queue.sv -----
`timescale 1ns / 1ps

module dbdf_queue import dbdf_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  job_xfer_type push,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output job_type      head
);

   localparam int PtrWidth   = $clog2(DEPTH);
   localparam int CountWidth = $clog2(DEPTH + 1);

   job_type               entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full       = count_ff == CountWidth'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + CountWidth'(1);
         2'b01:   count_in = count_ff - CountWidth'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("push into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

// ----- rtl/core/dbdf_back.sv -----
`timescale 1ns / 1ps

module dbdf_back import dbdf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    head_valid,
   input  job_type head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Stage 1: sign and magnitude of the padded corner offsets (Q.5)
   logic               v1_ff, v1_in;
   meta_type           meta1_ff;
   logic               sx1_ff, sx1_in, sy1_ff, sy1_in;
   logic [17:0]        mx1_ff, mx1_in, my1_ff, my1_in;
   logic [15:0]        bw1_ff, bh1_ff;
   logic [17:0]        posx, negx, posy, negy;

   // Stage 2: products with the inverse scale
   logic               v2_ff, v2_in;
   meta_type           meta2_ff;
   logic               sx2_ff, sy2_ff;
   logic [41:0]        px2_ff, px2_in, py2_ff, py2_in;
   logic [39:0]        pw2_ff, pw2_in, ph2_ff, ph2_in;

   // Stage 3: truncated corner and size in image pixels
   logic               v3_ff, v3_in;
   meta_type           meta3_ff;
   logic signed [21:0] lx3_ff, lx3_in, ty3_ff, ty3_in;
   logic [19:0]        wd3_ff, wd3_in, ht3_ff, ht3_in;

   // Stage 4: far edges
   logic               v4_ff, v4_in;
   meta_type           meta4_ff;
   logic signed [21:0] lx4_ff, ty4_ff;
   logic signed [22:0] rx4_ff, rx4_in, by4_ff, by4_in;

   // Clip and output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [13:0]        iw, ih;
   logic signed [22:0] x1, x2, y1, y2, dx, dy;
   logic               keep;

   logic               ld1, ld2, ld3, ld4, ld_out, drain4;

   // Load enables: a stage takes new data when empty or when it moves on
   assign ld_out = !rsp_valid_ff || !rsp_stall;
   assign drain4 = keep ? ld_out : 1'b1;
   assign ld4    = !v4_ff || drain4;
   assign ld3    = !v3_ff || ld4;
   assign ld2    = !v2_ff || ld3;
   assign ld1    = !v1_ff || ld2;
   assign pop    = head_valid && ld1;

   assign v1_in = ld1 ? head_valid : v1_ff;
   assign v2_in = ld2 ? v1_ff : v2_ff;
   assign v3_in = ld3 ? v2_ff : v3_ff;
   assign v4_in = ld4 ? v3_ff : v4_ff;

   // 2*c - (size + 32*pad), split into sign and magnitude
   always_comb begin
      posx   = {1'b0, head.center_x, 1'b0};
      negx   = {2'b0, head.box_w} + {1'b0, cfg.pad_left, 5'b0};
      posy   = {1'b0, head.center_y, 1'b0};
      negy   = {2'b0, head.box_h} + {1'b0, cfg.pad_top, 5'b0};
      sx1_in = posx < negx;
      sy1_in = posy < negy;
      mx1_in = sx1_in ? negx - posx : posx - negx;
      my1_in = sy1_in ? negy - posy : posy - negy;
   end

   assign px2_in = 42'(mx1_ff) * 42'(cfg.inverse_scale);
   assign py2_in = 42'(my1_ff) * 42'(cfg.inverse_scale);
   assign pw2_in = 40'(bw1_ff) * 40'(cfg.inverse_scale);
   assign ph2_in = 40'(bh1_ff) * 40'(cfg.inverse_scale);

   // Truncate the magnitude, then restore the sign: rounds toward zero
   assign lx3_in = sx2_ff ? -$signed({1'b0, px2_ff[41:21]}) : $signed({1'b0, px2_ff[41:21]});
   assign ty3_in = sy2_ff ? -$signed({1'b0, py2_ff[41:21]}) : $signed({1'b0, py2_ff[41:21]});
   assign wd3_in = pw2_ff[39:20];
   assign ht3_in = ph2_ff[39:20];

   assign rx4_in = 23'(lx3_ff) + $signed({3'b0, wd3_ff});
   assign by4_in = 23'(ty3_ff) + $signed({3'b0, ht3_ff});

   always_comb begin
      iw   = (cfg.image_width > 14'(ImgMax)) ? 14'(ImgMax) : cfg.image_width;
      ih   = (cfg.image_height > 14'(ImgMax)) ? 14'(ImgMax) : cfg.image_height;
      x1   = lx4_ff[21] ? '0 : 23'(lx4_ff);
      y1   = ty4_ff[21] ? '0 : 23'(ty4_ff);
      x2   = (rx4_ff < $signed({9'b0, iw})) ? rx4_ff : $signed({9'b0, iw});
      y2   = (by4_ff < $signed({9'b0, ih})) ? by4_ff : $signed({9'b0, ih});
      keep = (x2 > x1) && (y2 > y1);
      dx   = x2 - x1;
      dy   = y2 - y1;

      rsp_data_in.out_candidate  = meta4_ff.candidate_id;
      rsp_data_in.out_class      = meta4_ff.win_class;
      rsp_data_in.out_score      = meta4_ff.win_score;
      rsp_data_in.box_left       = x1[12:0];
      rsp_data_in.box_top        = y1[12:0];
      rsp_data_in.box_width_out  = dx[13:0];
      rsp_data_in.box_height_out = dy[13:0];

      // Drop empty boxes here; they never reach the output register
      rsp_valid_in = ld_out ? (v4_ff && keep) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         meta1_ff <= head.meta;
         sx1_ff   <= sx1_in;
         sy1_ff   <= sy1_in;
         mx1_ff   <= mx1_in;
         my1_ff   <= my1_in;
         bw1_ff   <= head.box_w;
         bh1_ff   <= head.box_h;
      end
      if (ld2) begin
         meta2_ff <= meta1_ff;
         sx2_ff   <= sx1_ff;
         sy2_ff   <= sy1_ff;
         px2_ff   <= px2_in;
         py2_ff   <= py2_in;
         pw2_ff   <= pw2_in;
         ph2_ff   <= ph2_in;
      end
      if (ld3) begin
         meta3_ff <= meta2_ff;
         lx3_ff   <= lx3_in;
         ty3_ff   <= ty3_in;
         wd3_ff   <= wd3_in;
         ht3_ff   <= ht3_in;
      end
      if (ld4) begin
         meta4_ff <= meta3_ff;
         lx4_ff   <= lx3_ff;
         ty4_ff   <= ty3_ff;
         rx4_ff   <= rx4_in;
         by4_ff   <= by4_in;
      end
      if (ld_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_box_inside_image: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.box_width_out != 14'd0 &&
                        rsp_data_ff.box_height_out != 14'd0 &&
                        (15'(rsp_data_ff.box_left) + 15'(rsp_data_ff.box_width_out))
                           <= 15'(ImgMax) &&
                        (15'(rsp_data_ff.box_top) + 15'(rsp_data_ff.box_height_out))
                           <= 15'(ImgMax)))
      else $error("emitted box empty or outside image");

   a_score_passed_threshold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.out_score != 16'd0 &&
                        rsp_data_ff.out_score >= cfg.score_threshold))
      else $error("emitted box below score threshold");

endmodule

// ----- rtl/core/detection_box_decode_filter.sv -----
// A kept box's last class score is classified combinationally in the front and written into the queue;
// the box then passes through four math stages and the output register to rsp_valid.
// Throughput: one class score per cycle while req_stall (queue full) is low, and the back end retires
// one box per cycle through a QUEUE_DEPTH-entry queue while rsp_stall is low.
// Reset is synchronous: clears argmax state, queue, pipeline and loads register defaults.
`timescale 1ns / 1ps

module detection_box_decode_filter import dbdf_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_wen,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   job_xfer_type push;
   logic         queue_full;
   logic         pop;
   logic         head_valid;
   job_type      head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_CLASS_NUM:       cfg_in.class_num       = csr_wdata[8:0];
            CSR_SCORE_THRESHOLD: cfg_in.score_threshold = csr_wdata[15:0];
            CSR_INVERSE_SCALE:   cfg_in.inverse_scale   = csr_wdata[23:0];
            CSR_PAD_LEFT:        cfg_in.pad_left        = csr_wdata[11:0];
            CSR_PAD_TOP:         cfg_in.pad_top         = csr_wdata[11:0];
            CSR_IMAGE_WIDTH:     cfg_in.image_width     = csr_wdata[13:0];
            CSR_IMAGE_HEIGHT:    cfg_in.image_height    = csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.class_num       <= 9'd80;
         cfg_ff.score_threshold <= 16'd16384;
         cfg_ff.inverse_scale   <= 24'd65536;
         cfg_ff.pad_left        <= 12'd0;
         cfg_ff.pad_top         <= 12'd0;
         cfg_ff.image_width     <= 14'd640;
         cfg_ff.image_height    <= 14'd640;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dbdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push)
   );

   dbdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   dbdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- bench/detection_box_decode_filter_test.sv -----
`timescale 1ns / 1ps

module detection_box_decode_filter_test;
   import dbdf_pkg::*;

   localparam int HoldCycles    = 200;
   localparam int DrainCycles   = 12;
   localparam int WatchdogLimit = 3000;
   localparam int ItemTarget    = 650;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_wen = 1'b0;
   csr_index_type csr_index = CSR_CLASS_NUM;
   logic [23:0]   csr_wdata = '0;

   // Register copies seen by the box predictor
   logic [8:0]  cfg_class_num       = 9'd80;
   logic [15:0] cfg_score_threshold = 16'd16384;
   logic [23:0] cfg_inverse_scale   = 24'd65536;
   logic [11:0] cfg_pad_left        = '0;
   logic [11:0] cfg_pad_top         = '0;
   logic [13:0] cfg_image_width     = 14'd640;
   logic [13:0] cfg_image_height    = 14'd640;

   // Running argmax of the predictor
   logic [15:0] top_score     = '0;
   logic [7:0]  top_class     = '0;
   bit          best_valid    = 1'b0;
   logic [7:0]  class_counter = '0;

   req_type score_queue[$];
   rsp_type kept_boxes[$];

   int  queued_items  = 0;
   int  error_count   = 0;
   int  stuck_cycles  = 0;
   int  idle_mode     = 0;
   int  tx_gap        = 0;
   int  rx_gap        = 0;
   int  hold_count    = 0;
   bit  hold_arm      = 1'b0;
   bit  hold_done     = 1'b0;
   bit  req_taken     = 1'b0;

   detection_box_decode_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int classes_per_candidate();
      if (cfg_class_num == 0) return 1;
      if (cfg_class_num > MaxClasses) return MaxClasses;
      return int'(cfg_class_num);
   endfunction

   // Q.5 edge times Q8.16 scale, truncated toward zero
   function automatic longint apply_inverse_scale(longint v);
      longint inv;
      inv = longint'(cfg_inverse_scale);
      if (v < 0) return -(((-v) * inv) >> 21);
      return (v * inv) >> 21;
   endfunction

   function automatic bit decode_score(input req_type item, output rsp_type box);
      int          count;
      logic [15:0] win_score;
      logic [7:0]  win_class;
      bit          win_valid;
      longint      lft, tp, wd, ht, iw, ih, x1, y1, x2, y2;
      box = '0;
      count = classes_per_candidate();
      if (item.class_score > top_score) begin
         top_score  = item.class_score;
         top_class  = class_counter;
         best_valid = 1'b1;
      end
      if (int'(class_counter) + 1 < count) begin
         class_counter = class_counter + 8'd1;
         return 1'b0;
      end
      win_score     = top_score;
      win_class     = top_class;
      win_valid     = best_valid;
      top_score     = '0;
      top_class     = '0;
      best_valid    = 1'b0;
      class_counter = '0;
      if (!win_valid || win_score < cfg_score_threshold) return 1'b0;
      lft = apply_inverse_scale(2 * longint'(item.center_x) - longint'(item.box_w_in)
                                - 32 * longint'(cfg_pad_left));
      tp  = apply_inverse_scale(2 * longint'(item.center_y) - longint'(item.box_h_in)
                                - 32 * longint'(cfg_pad_top));
      wd  = (longint'(item.box_w_in) * longint'(cfg_inverse_scale)) >> 20;
      ht  = (longint'(item.box_h_in) * longint'(cfg_inverse_scale)) >> 20;
      iw  = (cfg_image_width > ImgMax) ? ImgMax : longint'(cfg_image_width);
      ih  = (cfg_image_height > ImgMax) ? ImgMax : longint'(cfg_image_height);
      x1  = (lft > 0) ? lft : 0;
      y1  = (tp > 0) ? tp : 0;
      x2  = (lft + wd < iw) ? lft + wd : iw;
      y2  = (tp + ht < ih) ? tp + ht : ih;
      if (x2 <= x1 || y2 <= y1) return 1'b0;
      box.out_candidate  = item.candidate_id;
      box.out_class      = win_class;
      box.out_score      = win_score;
      box.box_left       = x1[12:0];
      box.box_top        = y1[12:0];
      box.box_width_out  = 14'(x2 - x1);
      box.box_height_out = 14'(y2 - y1);
      return 1'b1;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // Sample both channels; predict on each accepted score, check each accepted box
   always @(posedge clock) begin : monitor
      rsp_type box;
      rsp_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            if (decode_score(req_data, box)) kept_boxes = {kept_boxes, box};
         end
         if (rsp_valid && !rsp_stall) begin
            if (kept_boxes.size() == 0) begin
               $error("unexpected box for candidate %0d", rsp_data.out_candidate);
               error_count++;
            end else begin
               want = kept_boxes.pop_front();
               check_field("out_candidate", want.out_candidate, rsp_data.out_candidate);
               check_field("out_class", want.out_class, rsp_data.out_class);
               check_field("out_score", want.out_score, rsp_data.out_score);
               check_field("box_left", want.box_left, rsp_data.box_left);
               check_field("box_top", want.box_top, rsp_data.box_top);
               check_field("box_width_out", want.box_width_out, rsp_data.box_width_out);
               check_field("box_height_out", want.box_height_out, rsp_data.box_height_out);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
            if (stuck_cycles >= WatchdogLimit) begin
               $display("** detection_box_decode_filter: FAILED **");
               $finish;
            end
         end
      end
   end

   // Sender: hold a stalled transaction, otherwise idle in bursts or offer the next score
   always @(negedge clock) begin : driver
      logic    valid_next;
      req_type data_next;
      valid_next = req_valid;
      data_next  = req_data;
      if (reset) begin
         valid_next = 1'b0;
      end else if (!req_valid || req_taken) begin
         if (tx_gap > 0) begin
            valid_next = 1'b0;
            tx_gap--;
         end else if (idle_mode != 0 &&
                      $urandom_range(0, (idle_mode == 1) ? 15 : 3) == 0) begin
            valid_next = 1'b0;
            tx_gap = $urandom_range(0, 16);
         end else if (score_queue.size() != 0) begin
            valid_next = 1'b1;
            data_next  = score_queue.pop_front();
         end else begin
            valid_next = 1'b0;
         end
      end
      req_valid <= valid_next;
      req_data  <= data_next;
   end

   // Receiver: long hold-off when armed, else random stall bursts
   always @(negedge clock) begin : receiver
      logic stall_next;
      if (reset) begin
         stall_next = 1'b0;
      end else if (hold_arm && !hold_done) begin
         stall_next = 1'b1;
         if (hold_count == HoldCycles) hold_done = 1'b1;
         else hold_count++;
      end else if (rx_gap > 0) begin
         stall_next = 1'b1;
         rx_gap--;
      end else if (idle_mode != 0 &&
                   $urandom_range(0, (idle_mode == 1) ? 15 : 3) == 0) begin
         stall_next = 1'b1;
         rx_gap = $urandom_range(0, 16);
      end else begin
         stall_next = 1'b0;
      end
      rsp_stall <= stall_next;
   end

   task automatic write_register(csr_index_type idx, logic [23:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_CLASS_NUM:       cfg_class_num       = value[8:0];
         CSR_SCORE_THRESHOLD: cfg_score_threshold = value[15:0];
         CSR_INVERSE_SCALE:   cfg_inverse_scale   = value[23:0];
         CSR_PAD_LEFT:        cfg_pad_left        = value[11:0];
         CSR_PAD_TOP:         cfg_pad_top         = value[11:0];
         CSR_IMAGE_WIDTH:     cfg_image_width     = value[13:0];
         CSR_IMAGE_HEIGHT:    cfg_image_height    = value[13:0];
         default: ;
      endcase
   endtask

   task automatic load_filter_setup(logic [8:0] cc, logic [15:0] thr, logic [23:0] inv,
                                    logic [11:0] pl, logic [11:0] pt,
                                    logic [13:0] w, logic [13:0] h);
      write_register(CSR_CLASS_NUM, 24'(cc));
      write_register(CSR_SCORE_THRESHOLD, 24'(thr));
      write_register(CSR_INVERSE_SCALE, inv);
      write_register(CSR_PAD_LEFT, 24'(pl));
      write_register(CSR_PAD_TOP, 24'(pt));
      write_register(CSR_IMAGE_WIDTH, 24'(w));
      write_register(CSR_IMAGE_HEIGHT, 24'(h));
      @(negedge clock);
      csr_wen <= 1'b0;
      #1;
   endtask

   // Block until the input side is empty and every box has arrived, then drain the pipe
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (score_queue.size() != 0 || req_valid || kept_boxes.size() != 0);
      repeat (DrainCycles) @(posedge clock);
      #1;
   endtask

   task automatic push_item(logic [15:0] cand, logic [15:0] score, logic [15:0] cx,
                            logic [15:0] cy, logic [15:0] bw, logic [15:0] bh);
      req_type item;
      item.candidate_id = cand;
      item.class_score  = score;
      item.center_x     = cx;
      item.center_y     = cy;
      item.box_w_in     = bw;
      item.box_h_in     = bh;
      score_queue = {score_queue, item};
      queued_items++;
   endtask

   function automatic logic [15:0] pick_score(logic [15:0] prev);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return prev;
         2:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Boxes that mostly land inside the image under the current scale and padding
   function automatic req_type make_item(logic [15:0] cand, logic [15:0] score,
                                         bit plausible);
      req_type item;
      longint  ext_w, ext_h, scale;
      item.candidate_id = cand;
      item.class_score  = score;
      if (plausible && $urandom_range(0, 3) != 0) begin
         scale = (cfg_inverse_scale == 0) ? 1 : longint'(cfg_inverse_scale);
         ext_w = (longint'(cfg_image_width) << 16) / scale;
         ext_h = (longint'(cfg_image_height) << 16) / scale;
         if (ext_w > 2047) ext_w = 2047;
         if (ext_h > 2047) ext_h = 2047;
         item.center_x = 16'(16 * int'(cfg_pad_left) + $urandom_range(0, 16 * int'(ext_w)));
         item.center_y = 16'(16 * int'(cfg_pad_top) + $urandom_range(0, 16 * int'(ext_h)));
         item.box_w_in = 16'($urandom_range(16, 8 * int'(ext_w) + 16));
         item.box_h_in = 16'($urandom_range(16, 8 * int'(ext_h) + 16));
      end else begin
         item.center_x = 16'($urandom);
         item.center_y = 16'($urandom);
         item.box_w_in = 16'($urandom);
         item.box_h_in = 16'($urandom);
      end
      return item;
   endfunction

   task automatic queue_candidate(int n, bit plausible);
      logic [15:0] cand;
      logic [15:0] score;
      bit          all_zero;
      cand     = 16'($urandom);
      score    = '0;
      all_zero = ($urandom_range(0, 15) == 0);
      for (int i = 0; i < n; i++) begin
         score = all_zero ? 16'd0 : pick_score(score);
         score_queue = {score_queue, make_item(cand, score, plausible)};
         queued_items++;
      end
   endtask

   task automatic random_setup(output bit plausible);
      logic [15:0] thr;
      plausible = ($urandom_range(0, 9) < 7);
      if (plausible) begin
         case ($urandom_range(0, 5))
            0:       thr = '0;
            1:       thr = 16'hFFFF;
            default: thr = 16'($urandom_range(0, 40000));
         endcase
         load_filter_setup(9'($urandom_range(1, 8)), thr,
                           24'($urandom_range(32768, 131072)),
                           12'($urandom_range(0, 64)), 12'($urandom_range(0, 64)),
                           14'($urandom_range(64, 1024)), 14'($urandom_range(64, 1024)));
      end else begin
         load_filter_setup(9'($urandom_range(1, 16)), 16'($urandom), 24'($urandom),
                           12'($urandom), 12'($urandom), 14'($urandom), 14'($urandom));
      end
   endtask

   initial begin : stimulus
      int phase;
      int eff;
      bit plausible;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First maximum wins, all-zero candidate, clip at the left edge, score at threshold
      idle_mode = 1;
      load_filter_setup(9'd3, 16'd16384, 24'd65536, 12'd0, 12'd0, 14'd640, 14'd640);
      push_item(16'h0001, 16'd100, '0, '0, '0, '0);
      push_item(16'h0001, 16'd40000, '0, '0, '0, '0);
      push_item(16'h0001, 16'd40000, 16'd3200, 16'd3200, 16'd1600, 16'd1600);
      push_item(16'hFFFF, 16'd0, '0, '0, '0, '0);
      push_item(16'hFFFF, 16'd0, '0, '0, '0, '0);
      push_item(16'hFFFF, 16'd0, 16'd3200, 16'd3200, 16'd1600, 16'd1600);
      push_item(16'h0000, 16'hFFFF, '0, '0, '0, '0);
      push_item(16'h0000, 16'd0, '0, '0, '0, '0);
      push_item(16'h0000, 16'd16383, 16'd0, 16'd0, 16'd3200, 16'd3200);
      push_item(16'h00AA, 16'd0, '0, '0, '0, '0);
      push_item(16'h00AA, 16'd16384, '0, '0, '0, '0);
      push_item(16'h00AA, 16'd16383, 16'd6400, 16'd4800, 16'd800, 16'd960);
      wait_idle();

      // Class count of zero, oversized image width, extreme scale and padding
      idle_mode = 2;
      load_filter_setup(9'd0, 16'd0, 24'hFFFFFF, 12'hFFF, 12'hFFF, 14'h3FFF, 14'd8192);
      push_item(16'd2, 16'd0, 16'd3200, 16'd3200, 16'd1600, 16'd1600);
      push_item(16'd3, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_item(16'd4, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
      push_item(16'd5, 16'd2, 16'hFFFF, 16'hFFFF, 16'h0100, 16'h0100);
      wait_idle();

      // Zero inverse scale, then zero image width: nothing kept
      load_filter_setup(9'd1, 16'd0, 24'd0, 12'd0, 12'd0, 14'd640, 14'd640);
      push_item(16'd6, 16'd500, 16'd3200, 16'd3200, 16'd1600, 16'd1600);
      wait_idle();
      load_filter_setup(9'd1, 16'd0, 24'd65536, 12'd0, 12'd0, 14'd0, 14'd640);
      push_item(16'd7, 16'd500, 16'd3200, 16'd3200, 16'd1600, 16'd1600);
      wait_idle();

      // Shrink the class count in the middle of a candidate
      load_filter_setup(9'd4, 16'd0, 24'd65536, 12'd0, 12'd0, 14'd640, 14'd640);
      push_item(16'd8, 16'd10, '0, '0, '0, '0);
      push_item(16'd8, 16'd20, '0, '0, '0, '0);
      wait_idle();
      load_filter_setup(9'd2, 16'd0, 24'd65536, 12'd0, 12'd0, 14'd640, 14'd640);
      push_item(16'd8, 16'd5, 16'd3200, 16'd3200, 16'd1600, 16'd1600);
      push_item(16'd9, 16'd0, '0, '0, '0, '0);
      push_item(16'd9, 16'd7, 16'd4000, 16'd2000, 16'd640, 16'd320);
      wait_idle();

      // Back-pressure: hold the result side while single-class boxes keep coming
      idle_mode = 0;
      load_filter_setup(9'd1, 16'd1, 24'd65536, 12'd0, 12'd0, 14'd640, 14'd640);
      hold_arm = 1'b1;
      for (int i = 0; i < 40; i++) begin
         push_item(16'(i), 16'($urandom_range(1, 65535)), 16'($urandom_range(1600, 8000)),
                   16'($urandom_range(1600, 8000)), 16'($urandom_range(160, 3200)),
                   16'($urandom_range(160, 3200)));
      end
      wait (hold_done);
      wait_idle();

      phase = 0;
      while (queued_items < ItemTarget && phase < 200) begin
         if (phase == 4) begin
            // Class count above the limit: one full-size candidate
            load_filter_setup(9'd300, 16'd1000, 24'd65536, 12'd0, 12'd0,
                              14'd640, 14'd640);
            plausible = 1'b1;
         end else begin
            random_setup(plausible);
         end
         idle_mode = $urandom_range(0, 2);
         eff = classes_per_candidate();
         if (phase == 4) begin
            queue_candidate(eff, plausible);
         end else begin
            repeat ($urandom_range(4, 12)) queue_candidate(eff, plausible);
            // Leave a candidate unfinished across the next register update
            if (eff > 1 && $urandom_range(0, 3) == 0)
               queue_candidate($urandom_range(1, eff - 1), plausible);
         end
         wait_idle();
         phase++;
      end

      // Closing stretch without idling
      idle_mode = 0;
      load_filter_setup(9'd3, 16'd8000, 24'd65536, 12'd8, 12'd8, 14'd640, 14'd480);
      repeat (12) queue_candidate(classes_per_candidate(), 1'b1);
      wait_idle();

      if (error_count == 0)
         $display("** detection_box_decode_filter: PASSED **");
      else
         $display("** detection_box_decode_filter: FAILED **");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/dbdf_pkg.sv
rtl/core/dbdf_front.sv
rtl/core/dbdf_queue.sv
rtl/core/dbdf_back.sv
rtl/core/detection_box_decode_filter.sv
bench/detection_box_decode_filter_test.sv
